// ===== rtl/core/mswa_pkg.sv =====
// ----------------------------------------------------------------------------
// mswa_pkg
// Shared types, sizes and sample assembly for the sample window averager.
// ----------------------------------------------------------------------------
package mswa_pkg;

  localparam int unsigned WINDOW_LEN   = 16;
  localparam int unsigned NUM_CHANNELS = 64;
  localparam int unsigned NUM_ENERGY   = 4;

  localparam int unsigned CHAN_W   = 6;
  localparam int unsigned WORD_W   = 16;
  localparam int unsigned SAMPLE_W = 25;
  localparam int unsigned SUM_W    = 33;
  localparam int unsigned ENERGY_W = 64;
  localparam int unsigned DELTA_W  = WORD_W + 1;

  localparam int unsigned CH_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned SLOT_W  = $clog2(WINDOW_LEN);
  localparam int unsigned FILL_W  = $clog2(WINDOW_LEN + 1);
  localparam int unsigned EIDX_W  = (NUM_ENERGY > 1) ? $clog2(NUM_ENERGY) : 1;
  localparam int unsigned STORE_AW = CH_W + SLOT_W;

  typedef enum logic [1:0] {
    MODE_STORE  = 2'd0,
    MODE_ROUND  = 2'd1,
    MODE_QUERY  = 2'd2,
    MODE_ENERGY = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    VT_S24 = 2'd0,
    VT_U24 = 2'd1,
    VT_S16 = 2'd2,
    VT_U16 = 2'd3
  } vtype_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic              en;
    logic [CH_W-1:0]   chan;
    logic [SLOT_W-1:0] slot;
  } store_rd_t;

  typedef struct packed {
    logic                       en;
    logic [CH_W-1:0]            chan;
    logic [SLOT_W-1:0]          slot;
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [SUM_W-1:0]    sum;
  } store_wr_t;

  typedef struct packed {
    logic                      en;
    logic [CHAN_W-1:0]         chan;
    logic signed [DELTA_W-1:0] delta;
  } energy_req_t;

  function automatic logic signed [SAMPLE_W-1:0] assemble_sample(
    input vtype_e            vtype,
    input logic [WORD_W-1:0] hi,
    input logic [WORD_W-1:0] lo
  );
    logic signed [SAMPLE_W-1:0] res;
    case (vtype)
      VT_S24:  res = {hi[WORD_W-1], hi, lo[WORD_W-1:8]};
      VT_U24:  res = {1'b0, hi, lo[WORD_W-1:8]};
      VT_S16:  res = {{(SAMPLE_W-WORD_W){hi[WORD_W-1]}}, hi};
      VT_U16:  res = {{(SAMPLE_W-WORD_W){1'b0}}, hi};
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage

// ===== rtl/core/mswa_window_store.sv =====
// ----------------------------------------------------------------------------
// mswa_window_store
// Sample slot memory and running sum memory, one-cycle reads, with a
// clearing sweep after reset.
// ----------------------------------------------------------------------------
module mswa_window_store import mswa_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  store_rd_t                  rd_req_i,
  input  store_wr_t                  wr_req_i,
  output logic                       busy_o,
  output logic signed [SAMPLE_W-1:0] rd_sample_o,
  output logic signed [SUM_W-1:0]    rd_sum_o
);

  localparam int unsigned STORE_DEPTH = 1 << STORE_AW;
  localparam int unsigned SUM_DEPTH   = 1 << CH_W;

  logic signed [SAMPLE_W-1:0] sample_mem [STORE_DEPTH];
  logic signed [SUM_W-1:0]    sum_mem    [SUM_DEPTH];

  logic                       clr_busy_q;
  logic [STORE_AW-1:0]        clr_addr_q;
  logic signed [SAMPLE_W-1:0] rd_sample_q;
  logic signed [SUM_W-1:0]    rd_sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == '1) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      sample_mem[clr_addr_q]                  <= '0;
      sum_mem[clr_addr_q[STORE_AW-1:SLOT_W]]  <= '0;
    end else if (wr_req_i.en) begin
      sample_mem[{wr_req_i.chan, wr_req_i.slot}] <= wr_req_i.sample;
      sum_mem[wr_req_i.chan]                     <= wr_req_i.sum;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_req_i.en) begin
      rd_sample_q <= sample_mem[{rd_req_i.chan, rd_req_i.slot}];
      rd_sum_q    <= sum_mem[rd_req_i.chan];
    end
  end

  assign busy_o      = clr_busy_q;
  assign rd_sample_o = rd_sample_q;
  assign rd_sum_o    = rd_sum_q;

endmodule

// ===== rtl/core/mswa_energy_acc.sv =====
// ----------------------------------------------------------------------------
// mswa_energy_acc
// Wrapping 64-bit energy totals, updated by a signed net increment.
// ----------------------------------------------------------------------------
module mswa_energy_acc import mswa_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  energy_req_t                req_i,
  output logic signed [ENERGY_W-1:0] total_o
);

  logic signed [ENERGY_W-1:0] totals_q [NUM_ENERGY];
  logic signed [ENERGY_W-1:0] next_total;
  logic                       hit;
  logic [EIDX_W-1:0]          idx;

  assign hit        = int'(req_i.chan) < NUM_ENERGY;
  assign idx        = req_i.chan[EIDX_W-1:0];
  assign next_total = totals_q[idx]
                    + {{(ENERGY_W-DELTA_W){req_i.delta[DELTA_W-1]}}, req_i.delta};
  assign total_o    = hit ? next_total : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_ENERGY; i++) begin
        totals_q[i] <= '0;
      end
    end else if (req_i.en && hit) begin
      totals_q[idx] <= next_total;
    end
  end

endmodule

// ===== rtl/core/meter_sample_window_averager.sv =====
// ----------------------------------------------------------------------------
// meter_sample_window_averager
// Per-channel moving window of meter samples with running sums, a shared
// round position, window queries and wrapping energy totals.
// ----------------------------------------------------------------------------
// The sample and sum memories are read in the cycle of acceptance and the
// modified entry is written back in the next, so no request is accepted
// while one is executing. The result sits in an output register, and the
// next request is taken as soon as that register is free or being emptied.
// After reset a sweep clears the sample and sum memories; no request is
// accepted until it has finished.
module meter_sample_window_averager import mswa_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // channel[5:0], high_word[21:6], low_word[37:22], energy_forward[53:38],
  // energy_reverse[69:54], zero pad[71:70]
  input  logic [71:0]  s_axis_tdata,
  // mode[1:0], value_type[3:2]
  input  logic [3:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // sample_value[24:0], window_sum[57:25], energy_total[121:58], zero pad[127:122]
  output logic [127:0] m_axis_tdata,
  // window_ready[0]
  output logic         m_axis_tuser
);

  state_e                     state_q, state_d;
  logic                       in_acc, exec;
  logic                       store_busy;

  mode_e                      mode_q;
  vtype_e                     vtype_q;
  logic [CHAN_W-1:0]          chan_q;
  logic [WORD_W-1:0]          hi_q, lo_q;
  logic signed [DELTA_W-1:0]  delta_q;

  logic [SLOT_W-1:0]          slot_q, slot_d;
  logic [FILL_W-1:0]          fill_q, fill_d;

  logic                       m_valid_q;
  logic signed [SAMPLE_W-1:0] out_sample_q;
  logic signed [SUM_W-1:0]    out_sum_q;
  logic                       out_ready_q;
  logic signed [ENERGY_W-1:0] out_energy_q;

  store_rd_t                  rd_req;
  store_wr_t                  wr_req;
  energy_req_t                e_req;
  logic signed [SAMPLE_W-1:0] rd_sample;
  logic signed [SUM_W-1:0]    rd_sum;
  logic signed [ENERGY_W-1:0] e_total;
  logic signed [SAMPLE_W-1:0] sample_v;
  logic                       ch_ok;

  assign s_axis_tready = (state_q == ST_IDLE) && !store_busy
                      && (!m_valid_q || m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    exec    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        exec    = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // hold the request payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q  <= mode_e'(s_axis_tuser[1:0]);
      vtype_q <= vtype_e'(s_axis_tuser[3:2]);
      chan_q  <= s_axis_tdata[5:0];
      hi_q    <= s_axis_tdata[21:6];
      lo_q    <= s_axis_tdata[37:22];
      delta_q <= $signed({1'b0, s_axis_tdata[53:38]}) - $signed({1'b0, s_axis_tdata[69:54]});
    end
  end

  assign rd_req.en   = in_acc;
  assign rd_req.chan = s_axis_tdata[CH_W-1:0];
  assign rd_req.slot = slot_q;

  assign sample_v = assemble_sample(vtype_q, hi_q, lo_q);
  assign ch_ok    = int'(chan_q) < NUM_CHANNELS;

  assign wr_req.en     = exec && (mode_q == MODE_STORE) && ch_ok;
  assign wr_req.chan   = chan_q[CH_W-1:0];
  assign wr_req.slot   = slot_q;
  assign wr_req.sample = sample_v;
  assign wr_req.sum    = rd_sum + SUM_W'(sample_v) - SUM_W'(rd_sample);

  assign e_req.en    = exec && (mode_q == MODE_ENERGY);
  assign e_req.chan  = chan_q;
  assign e_req.delta = delta_q;

  mswa_window_store u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_req_i    (rd_req),
    .wr_req_i    (wr_req),
    .busy_o      (store_busy),
    .rd_sample_o (rd_sample),
    .rd_sum_o    (rd_sum)
  );

  mswa_energy_acc u_energy (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (e_req),
    .total_o (e_total)
  );

  // advance the round position and count down the fill
  always_comb begin
    slot_d = slot_q;
    fill_d = fill_q;
    if (exec && (mode_q == MODE_ROUND)) begin
      slot_d = (slot_q == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_q + 1'b1;
      if (fill_q != '0) begin
        fill_d = fill_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      fill_q <= FILL_W'(WINDOW_LEN);
    end else begin
      slot_q <= slot_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (exec) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      out_sample_q <= (mode_q == MODE_STORE) ? sample_v : '0;
      out_sum_q    <= ((mode_q == MODE_QUERY) && ch_ok) ? rd_sum : '0;
      out_ready_q  <= (mode_q == MODE_QUERY) && ch_ok && (fill_q == '0);
      out_energy_q <= (mode_q == MODE_ENERGY) ? e_total : '0;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'd0, out_energy_q, out_sum_q, out_sample_q};
  assign m_axis_tuser  = out_ready_q;

  a_no_accept_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_busy |-> !s_axis_tready)
    else $error("request accepted during clearing sweep");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> ##1 m_axis_tvalid)
    else $error("result not presented two cycles after acceptance");

  a_ready_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (fill_q == '0))
    else $error("window ready flagged before window filled");

  a_no_write_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_req.en |-> !store_busy)
    else $error("store write during clearing sweep");

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of meter_sample_window_averager: a directed table walks
// sample assembly extremes, overwrites, window fill and wrap, and energy index
// limits, then random requests run under three sender/receiver idle mixes.
// Results are checked field by field: cycle-free predictor or table values.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mswa_pkg::*;

  localparam int unsigned RANDOM_PER_PHASE = 334;
  localparam int unsigned DRAIN_CYCLES     = 8;
  localparam logic [15:0] HI_CORNERS [4] = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF};

  typedef struct packed {
    mode_e       mode;
    logic [5:0]  channel;
    vtype_e      vtype;
    logic [15:0] hi;
    logic [15:0] lo;
    logic [15:0] fwd;
    logic [15:0] rev;
  } request_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [SUM_W-1:0]    sum;
    logic                ready;
    logic [ENERGY_W-1:0] energy;
  } result_t;

  typedef struct packed {
    request_t   req;
    logic [4:0] reps;
    logic       typed;
    result_t    res;
  } directed_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [71:0]  s_axis_tdata = '0;
  logic [3:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic         m_axis_tuser;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatch_count = 0;

  result_t awaited_results[$];

  int          slot_samples [NUM_CHANNELS][WINDOW_LEN];
  longint      window_sums  [NUM_CHANNELS];
  int          write_pos;
  int          rounds_left;
  logic [63:0] energy_acc   [NUM_ENERGY];

  meter_sample_window_averager dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #4 clk_i = ~clk_i;

  function automatic result_t compute_window_result(input request_t r);
    result_t res;
    int      h;
    int      v;
    res = '0;
    case (r.mode)
      MODE_STORE: begin
        h = r.hi[15] ? int'(r.hi) - 65536 : int'(r.hi);
        case (r.vtype)
          VT_S24:  v = h * 256 + int'(r.lo[15:8]);
          VT_U24:  v = int'(r.hi) * 256 + int'(r.lo[15:8]);
          VT_S16:  v = h;
          default: v = int'(r.hi);
        endcase
        if (r.channel < NUM_CHANNELS) begin
          window_sums[r.channel] += longint'(v) - longint'(slot_samples[r.channel][write_pos]);
          slot_samples[r.channel][write_pos] = v;
        end
        res.sample = SAMPLE_W'(v);
      end
      MODE_ROUND: begin
        write_pos = (write_pos + 1) % WINDOW_LEN;
        if (rounds_left != 0) rounds_left--;
      end
      MODE_QUERY: begin
        if (r.channel < NUM_CHANNELS) begin
          res.sum   = SUM_W'(window_sums[r.channel]);
          res.ready = (rounds_left == 0);
        end
      end
      default: begin
        if (r.channel < NUM_ENERGY) begin
          energy_acc[r.channel] = energy_acc[r.channel] + 64'(r.fwd) - 64'(r.rev);
          res.energy = energy_acc[r.channel];
        end
      end
    endcase
    return res;
  endfunction

  function automatic request_t random_request();
    request_t    r;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 50) r.mode = MODE_STORE;
    else if (pick < 58) r.mode = MODE_ROUND;
    else if (pick < 83) r.mode = MODE_QUERY;
    else r.mode = MODE_ENERGY;
    r.channel = 6'($urandom_range(63));
    if (r.mode == MODE_ENERGY && $urandom_range(99) < 80)
      r.channel = 6'($urandom_range(NUM_ENERGY - 1));
    r.vtype = vtype_e'($urandom_range(3));
    r.hi  = ($urandom_range(9) == 0) ? HI_CORNERS[$urandom_range(3)] : 16'($urandom);
    r.lo  = 16'($urandom);
    r.fwd = ($urandom_range(15) == 0) ? 16'hFFFF : 16'($urandom);
    r.rev = ($urandom_range(15) == 0) ? 16'h0000 : 16'($urandom);
    return r;
  endfunction

  task automatic send_request(input request_t r, input logic typed, input result_t typed_res);
    result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, r.rev, r.fwd, r.lo, r.hi, r.channel};
    s_axis_tuser  <= {r.vtype, r.mode};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predicted = compute_window_result(r);
    awaited_results.push_back(typed ? typed_res : predicted);
    @(negedge clk_i);
  endtask

  task automatic wait_for_results();
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin : result_check
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[24:0], m_axis_tdata[57:25], m_axis_tuser, m_axis_tdata[121:58]};
      if (awaited_results.size() == 0) begin
        $display("%0t: result expected none, got %h", $time, got);
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        if (got.sample !== want.sample) begin
          $display("%0t: sample_value expected %h, got %h", $time, want.sample, got.sample);
          mismatch_count++;
        end
        if (got.sum !== want.sum) begin
          $display("%0t: window_sum expected %h, got %h", $time, want.sum, got.sum);
          mismatch_count++;
        end
        if (got.ready !== want.ready) begin
          $display("%0t: window_ready expected %b, got %b", $time, want.ready, got.ready);
          mismatch_count++;
        end
        if (got.energy !== want.energy) begin
          $display("%0t: energy_total expected %h, got %h", $time, want.energy, got.energy);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #4ms;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    directed_row_t directed_rows[$];
    foreach (slot_samples[c, s]) slot_samples[c][s] = 0;
    foreach (window_sums[c]) window_sums[c] = 0;
    foreach (energy_acc[e]) energy_acc[e] = '0;
    write_pos   = 0;
    rounds_left = WINDOW_LEN;

    directed_rows.push_back('{'{MODE_QUERY, 6'd0, VT_S24, 16'h0000, 16'h0000, 16'h0000,
      16'h0000}, 5'd1, 1'b1, '{25'h0, 33'h0, 1'b0, 64'h0}});
    directed_rows.push_back('{'{MODE_STORE, 6'd0, VT_S24, 16'h8000, 16'h0000, 16'h0000,
      16'h0000}, 5'd1, 1'b1, '{25'h1800000, 33'h0, 1'b0, 64'h0}});
    directed_rows.push_back('{'{MODE_STORE, 6'd1, VT_U24, 16'hFFFF, 16'hFFFF, 16'hFFFF,
      16'hFFFF}, 5'd1, 1'b1, '{25'h0FFFFFF, 33'h0, 1'b0, 64'h0}});
    directed_rows.push_back('{'{MODE_STORE, 6'd2, VT_S16, 16'h8000, 16'hFFFF, 16'h0000,
      16'h0000}, 5'd1, 1'b1, '{25'h1FF8000, 33'h0, 1'b0, 64'h0}});
    directed_rows.push_back('{'{MODE_STORE, 6'd63, VT_U16, 16'hFFFF, 16'h1234, 16'h0000,
      16'h0000}, 5'd1, 1'b1, '{25'h000FFFF, 33'h0, 1'b0, 64'h0}});
    directed_rows.push_back('{'{MODE_STORE, 6'd0, VT_S24, 16'h7FFF, 16'hFF00, 16'h0000,
      16'h0000}, 5'd1, 1'b1, '{25'h07FFFFF, 33'h0, 1'b0, 64'h0}});
    directed_rows.push_back('{'{MODE_STORE, 6'd3, VT_S16, 16'h7FFF, 16'h0000, 16'h0000,
      16'h0000}, 5'd1, 1'b0, '0});
    directed_rows.push_back('{'{MODE_QUERY, 6'd0, VT_S24, 16'h0000, 16'h0000, 16'h0000,
      16'h0000}, 5'd1, 1'b0, '0});
    directed_rows.push_back('{'{MODE_QUERY, 6'd63, VT_S24, 16'h0000, 16'h0000, 16'h0000,
      16'h0000}, 5'd1, 1'b0, '0});
    directed_rows.push_back('{'{MODE_ROUND, 6'd0, VT_S24, 16'h0000, 16'h0000, 16'h0000,
      16'h0000}, 5'd1, 1'b0, '0});
    directed_rows.push_back('{'{MODE_STORE, 6'd0, VT_S24, 16'hFFFF, 16'hFF00, 16'h0000,
      16'h0000}, 5'd1, 1'b1, '{25'h1FFFFFF, 33'h0, 1'b0, 64'h0}});
    directed_rows.push_back('{'{MODE_QUERY, 6'd0, VT_S24, 16'h0000, 16'h0000, 16'h0000,
      16'h0000}, 5'd1, 1'b0, '0});
    directed_rows.push_back('{'{MODE_ENERGY, 6'd0, VT_S24, 16'h0000, 16'h0000, 16'h0000,
      16'h0001}, 5'd1, 1'b1, '{25'h0, 33'h0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF}});
    directed_rows.push_back('{'{MODE_ENERGY, 6'd0, VT_S24, 16'h0000, 16'h0000, 16'hFFFF,
      16'h0000}, 5'd1, 1'b0, '0});
    directed_rows.push_back('{'{MODE_ENERGY, 6'd3, VT_S24, 16'h0000, 16'h0000, 16'hFFFF,
      16'hFFFF}, 5'd1, 1'b0, '0});
    directed_rows.push_back('{'{MODE_ENERGY, 6'd4, VT_S24, 16'h0000, 16'h0000, 16'hFFFF,
      16'h0000}, 5'd1, 1'b1, '{25'h0, 33'h0, 1'b0, 64'h0}});
    directed_rows.push_back('{'{MODE_ENERGY, 6'd63, VT_S24, 16'h0000, 16'h0000, 16'hFFFF,
      16'hFFFF}, 5'd1, 1'b1, '{25'h0, 33'h0, 1'b0, 64'h0}});
    directed_rows.push_back('{'{MODE_ROUND, 6'd0, VT_S24, 16'h0000, 16'h0000, 16'h0000,
      16'h0000}, 5'd14, 1'b0, '0});
    directed_rows.push_back('{'{MODE_QUERY, 6'd0, VT_S24, 16'h0000, 16'h0000, 16'h0000,
      16'h0000}, 5'd1, 1'b0, '0});
    directed_rows.push_back('{'{MODE_ROUND, 6'd0, VT_S24, 16'h0000, 16'h0000, 16'h0000,
      16'h0000}, 5'd1, 1'b0, '0});
    directed_rows.push_back('{'{MODE_QUERY, 6'd0, VT_S24, 16'h0000, 16'h0000, 16'h0000,
      16'h0000}, 5'd1, 1'b0, '0});
    directed_rows.push_back('{'{MODE_ROUND, 6'd0, VT_S24, 16'h0000, 16'h0000, 16'h0000,
      16'h0000}, 5'd2, 1'b0, '0});
    directed_rows.push_back('{'{MODE_STORE, 6'd1, VT_S24, 16'h0000, 16'h00FF, 16'h0000,
      16'h0000}, 5'd1, 1'b1, '{25'h0, 33'h0, 1'b0, 64'h0}});
    directed_rows.push_back('{'{MODE_QUERY, 6'd1, VT_S24, 16'h0000, 16'h0000, 16'h0000,
      16'h0000}, 5'd1, 1'b0, '0});

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i])
      repeat (directed_rows[i].reps)
        send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res);
    s_axis_tvalid <= 1'b0;
    wait_for_results();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 84 : 0;
      recv_idle_pct = (phase == 0) ? 84 : (phase == 1) ? 31 : 0;
      repeat (RANDOM_PER_PHASE) send_request(random_request(), 1'b0, '0);
      // hold off until the block has handed back every request
      s_axis_tvalid <= 1'b0;
      wait_for_results();
    end

    if (mismatch_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
